// File: src/npfla_pkg.sv
// Package with the constants, codes and types shared by the node pool allocator files.
`timescale 1ns / 1ps
`default_nettype none

package npfla_pkg;

    localparam int CAPACITY  = 1024;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = IDX_W + 1;
    localparam int LINK_W    = 11;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int OPCODE_W  = 3;

    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 104;

    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(1024);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACQUIRE     = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_READ_ORDER  = 3'd2,
        OP_READ_LINKS  = 3'd3,
        OP_WRITE_LINKS = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_INACTIVE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic                 active;
        logic [LINK_W-1:0]    prev_link;
        logic [LINK_W-1:0]    next_link;
        logic [PAYLOAD_W-1:0] payload;
    } node_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] rd_sp;
        logic             node_wr_en;
        logic [IDX_W-1:0] node_wr_idx;
        node_t            node_wr_data;
        logic             push_en;
        logic [IDX_W-1:0] push_sp;
        logic [IDX_W-1:0] push_idx;
    } store_req_t;

endpackage

`default_nettype wire

// File: src/npfla_store.sv
// Node memory and free-index stack memory, both with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module npfla_store (
    input  wire logic                aclk,
    input  wire npfla_pkg::store_req_t req,
    output npfla_pkg::node_t         node_rd,
    output logic [npfla_pkg::IDX_W-1:0] stack_rd
);
    import npfla_pkg::*;

    node_t            node_mem  [CAPACITY];
    logic [IDX_W-1:0] stack_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.node_wr_en) begin
            node_mem[req.node_wr_idx] <= req.node_wr_data;
        end
        if (req.rd_en) begin
            node_rd <= node_mem[req.rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.push_en) begin
            stack_mem[req.push_sp] <= req.push_idx;
        end
        if (req.rd_en) begin
            stack_rd <= stack_mem[req.rd_sp];
        end
    end

endmodule

`default_nettype wire

// File: src/node_pool_free_list_allocator.sv
// Top level of the node pool allocator: handshake, sequencing and per-operation logic.
`timescale 1ns / 1ps
`default_nettype none

// A pool of 1024 nodes, each holding a 64-bit payload, next and previous link words
// (1024 meaning none) and an active bit. Every input item is one operation and gives
// exactly one result item. Acquire hands out the most recently released index, or the
// next never-used index when nothing has been released, and reports pool full when
// neither exists. Release, read order, read links and write links check that the index
// lies below the number of indices ever handed out and that the node is active. In
// the accept cycle the node entry and the top of the free stack are read from their
// synchronous memories; in the execute state the result is decided and the entry
// written back. The result waits in an output register; while it is not taken, a
// following item is accepted and then held at its write-back cycle.
// No memory is cleared after reset: the high-water count shows which entries are valid.

module node_pool_free_list_allocator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // opcode [2:0], node_index [12:3], order_payload [76:13], next_link_in [87:77],
    // prev_link_in [98:88], zero [103:99]
    input  wire logic [npfla_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status [1:0], granted_index [11:2], order_out [75:12], next_link_out [86:76],
    // prev_link_out [97:87], zero [103:98]
    output logic [npfla_pkg::M_DATA_W-1:0]       m_tdata
);
    import npfla_pkg::*;

    // Current state and operation registers.
    state_t               state_reg, state_next;
    logic [OPCODE_W-1:0]  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [LINK_W-1:0]    next_in_reg;
    logic [LINK_W-1:0]    prev_in_reg;

    // Free stack depth and high-water mark of handed out indices.
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic [CNT_W-1:0]     used_count_reg, used_count_next;

    // Result register.
    logic                 m_valid_reg, m_valid_next;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     granted_reg, granted_next;
    logic [PAYLOAD_W-1:0] order_reg, order_next;
    logic [LINK_W-1:0]    next_out_reg, next_out_next;
    logic [LINK_W-1:0]    prev_out_reg, prev_out_next;

    store_req_t           req;
    node_t                node_rd;
    logic [IDX_W-1:0]     stack_rd;

    logic                 accept;
    logic                 commit;
    status_t              chk;
    logic [CNT_W-1:0]     sp_dec;

    npfla_store u_store (
        .aclk     (aclk),
        .req      (req),
        .node_rd  (node_rd),
        .stack_rd (stack_rd)
    );

    assign accept = s_tvalid && s_tready;
    // The write-back cycle completes only when the result register can take the answer.
    assign commit = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
    assign sp_dec = free_count_reg - CNT_W'(1);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output decode of the state.
    always_comb begin
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_EXEC:  s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // Node check against the high-water mark and the stored active bit.
    always_comb begin
        if ({1'b0, idx_reg} >= used_count_reg) begin
            chk = STAT_RANGE;
        end else if (!node_rd.active) begin
            chk = STAT_INACTIVE;
        end else begin
            chk = STAT_OK;
        end
    end

    // Memory requests, counter updates and the result of the operation in flight.
    always_comb begin
        req              = '0;
        req.rd_en        = accept;
        req.rd_idx       = s_tdata[12:3];
        req.rd_sp        = sp_dec[IDX_W-1:0];
        req.push_sp      = free_count_reg[IDX_W-1:0];
        req.push_idx     = idx_reg;
        req.node_wr_idx  = idx_reg;
        req.node_wr_data = node_rd;

        free_count_next = free_count_reg;
        used_count_next = used_count_reg;

        status_next   = STAT_OK;
        granted_next  = '0;
        order_next    = '0;
        next_out_next = LINK_NONE;
        prev_out_next = LINK_NONE;

        case (op_reg)
            OP_ACQUIRE: begin
                req.node_wr_data = '{active: 1'b1, prev_link: LINK_NONE,
                                     next_link: LINK_NONE, payload: payload_reg};
                if (free_count_reg != '0) begin
                    req.node_wr_en  = commit;
                    req.node_wr_idx = stack_rd;
                    granted_next    = stack_rd;
                    if (commit) begin
                        free_count_next = sp_dec;
                    end
                end else if (used_count_reg < CAP_CNT) begin
                    req.node_wr_en  = commit;
                    req.node_wr_idx = used_count_reg[IDX_W-1:0];
                    granted_next    = used_count_reg[IDX_W-1:0];
                    if (commit) begin
                        used_count_next = used_count_reg + CNT_W'(1);
                    end
                end else begin
                    status_next = STAT_FULL;
                end
            end
            OP_RELEASE: begin
                status_next = chk;
                if (chk == STAT_OK) begin
                    req.node_wr_en   = commit;
                    req.node_wr_data = '{active: 1'b0, prev_link: LINK_NONE,
                                         next_link: LINK_NONE, payload: node_rd.payload};
                    if (free_count_reg < CAP_CNT) begin
                        req.push_en = commit;
                        if (commit) begin
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            OP_READ_ORDER: begin
                status_next = chk;
                if (chk == STAT_OK) begin
                    order_next = node_rd.payload;
                end
            end
            OP_READ_LINKS: begin
                status_next = chk;
                if (chk == STAT_OK) begin
                    next_out_next = node_rd.next_link;
                    prev_out_next = node_rd.prev_link;
                end
            end
            OP_WRITE_LINKS: begin
                status_next = chk;
                if (chk == STAT_OK) begin
                    req.node_wr_en   = commit;
                    req.node_wr_data = '{active: 1'b1, prev_link: prev_in_reg,
                                         next_link: next_in_reg, payload: node_rd.payload};
                    next_out_next    = next_in_reg;
                    prev_out_next    = prev_in_reg;
                end
            end
            default: begin
                // Unused opcodes leave the pool alone and report success.
                status_next = STAT_OK;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            used_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            used_count_reg <= used_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Operation and result payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_tdata[2:0];
            idx_reg     <= s_tdata[12:3];
            payload_reg <= s_tdata[76:13];
            next_in_reg <= s_tdata[87:77];
            prev_in_reg <= s_tdata[98:88];
        end
        if (commit) begin
            status_reg   <= status_next;
            granted_reg  <= granted_next;
            order_reg    <= order_next;
            next_out_reg <= next_out_next;
            prev_out_reg <= prev_out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, prev_out_reg, next_out_reg, order_reg, granted_reg, status_reg};

    // Every index on the free stack was once handed out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= used_count_reg)
        else $error("free stack deeper than the number of indices handed out");

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= CAP_CNT)
        else $error("high-water mark beyond the pool capacity");

    // A finished operation always leaves a result waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid)
        else $error("completed operation produced no result");

    // A successful acquire moves exactly one of the two counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == OP_ACQUIRE && status_next == STAT_OK) |=>
        ((free_count_reg == $past(free_count_reg) - CNT_W'(1)) !=
         (used_count_reg == $past(used_count_reg) + CNT_W'(1))))
        else $error("acquire did not take exactly one index");

endmodule

`default_nettype wire

// File: dv/node_pool_result_checker.sv
// Checker for the node pool allocator: predicts each result item and compares it.
`timescale 1ns / 1ps

module node_pool_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [npfla_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [npfla_pkg::M_DATA_W-1:0]  m_tdata,
    output int                                   pending,
    output int                                   fail_count,
    output int                                   results_seen,
    output int                                   full_seen,
    output int                                   range_seen,
    output int                                   inactive_seen,
    output int                                   high_water,
    output logic [npfla_pkg::CAPACITY-1:0]       live_map
);
    import npfla_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        status_t              status;
        logic [IDX_W-1:0]     granted;
        logic [PAYLOAD_W-1:0] order;
        logic [LINK_W-1:0]    next_link;
        logic [LINK_W-1:0]    prev_link;
    } pool_reply_t;

    // Shadow copy of the pool. Payload and link entries are only read for
    // live nodes, and the free stack only below its depth.
    logic [PAYLOAD_W-1:0] payload_mem [CAPACITY];
    logic [LINK_W-1:0]    next_mem    [CAPACITY];
    logic [LINK_W-1:0]    prev_mem    [CAPACITY];
    logic [IDX_W-1:0]     free_stack  [CAPACITY];
    int                   free_depth;
    pool_reply_t          awaited_replies [$];

    function automatic pool_reply_t apply_pool_op(input logic [OPCODE_W-1:0]  op,
                                                  input logic [IDX_W-1:0]     idx,
                                                  input logic [PAYLOAD_W-1:0] payload,
                                                  input logic [LINK_W-1:0]    nxt,
                                                  input logic [LINK_W-1:0]    prv);
        pool_reply_t      r;
        status_t          node_chk;
        logic [IDX_W-1:0] slot;
        bit               granted_ok;

        r.status    = STAT_OK;
        r.granted   = '0;
        r.order     = '0;
        r.next_link = LINK_NONE;
        r.prev_link = LINK_NONE;
        granted_ok  = 1'b1;
        slot        = '0;

        if (int'(idx) >= high_water)
            node_chk = STAT_RANGE;
        else if (!live_map[idx])
            node_chk = STAT_INACTIVE;
        else
            node_chk = STAT_OK;

        case (op)
            OP_ACQUIRE: begin
                if (free_depth > 0) begin
                    free_depth--;
                    slot = free_stack[free_depth];
                end else if (high_water < CAPACITY) begin
                    slot = IDX_W'(high_water);
                    high_water++;
                end else begin
                    r.status   = STAT_FULL;
                    granted_ok = 1'b0;
                end
                if (granted_ok) begin
                    payload_mem[slot] = payload;
                    next_mem[slot]    = LINK_NONE;
                    prev_mem[slot]    = LINK_NONE;
                    live_map[slot]    = 1'b1;
                    r.granted         = slot;
                end
            end
            OP_RELEASE: begin
                if (node_chk != STAT_OK) begin
                    r.status = node_chk;
                end else begin
                    next_mem[idx] = LINK_NONE;
                    prev_mem[idx] = LINK_NONE;
                    live_map[idx] = 1'b0;
                    if (free_depth < CAPACITY) begin
                        free_stack[free_depth] = idx;
                        free_depth++;
                    end
                end
            end
            OP_READ_ORDER: begin
                if (node_chk != STAT_OK)
                    r.status = node_chk;
                else
                    r.order = payload_mem[idx];
            end
            OP_READ_LINKS: begin
                if (node_chk != STAT_OK) begin
                    r.status = node_chk;
                end else begin
                    r.next_link = next_mem[idx];
                    r.prev_link = prev_mem[idx];
                end
            end
            OP_WRITE_LINKS: begin
                if (node_chk != STAT_OK) begin
                    r.status = node_chk;
                end else begin
                    next_mem[idx] = nxt;
                    prev_mem[idx] = prv;
                    r.next_link   = nxt;
                    r.prev_link   = prv;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch_channels
        pool_reply_t want;
        pool_reply_t got;
        logic [M_DATA_W-99:0] pad;
        bit          bad;

        if (!aresetn) begin
            live_map     = '0;
            free_depth   = 0;
            high_water   = 0;
            awaited_replies.delete();
            pending      = 0;
            fail_count   = 0;
            results_seen = 0;
            full_seen    = 0;
            range_seen   = 0;
            inactive_seen = 0;
        end else begin
            // The result leaving now always belongs to an older item, so it is
            // matched before the item accepted at this edge is predicted.
            if (m_tvalid && m_tready) begin
                got.status    = status_t'(m_tdata[1:0]);
                got.granted   = m_tdata[11:2];
                got.order     = m_tdata[75:12];
                got.next_link = m_tdata[86:76];
                got.prev_link = m_tdata[97:87];
                pad           = m_tdata[M_DATA_W-1:98];
                results_seen++;
                if (awaited_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Result %0d arrived with nothing awaited: %h",
                                 results_seen, m_tdata);
                end else begin
                    want = awaited_replies.pop_front();
                    case (want.status)
                        STAT_FULL:     full_seen++;
                        STAT_RANGE:    range_seen++;
                        STAT_INACTIVE: inactive_seen++;
                        default: ;
                    endcase
                    bad = (got.status != want.status) || (got.granted != want.granted) ||
                          (got.order != want.order) || (got.next_link != want.next_link) ||
                          (got.prev_link != want.prev_link) || (pad != '0);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("Item %0d want: st %0d idx %0d ord %h nxt %0d prv %0d",
                                     results_seen, want.status, want.granted, want.order,
                                     want.next_link, want.prev_link);
                            $display("Item %0d got:  st %0d idx %0d ord %h nxt %0d prv %0d pad %h",
                                     results_seen, got.status, got.granted, got.order,
                                     got.next_link, got.prev_link, pad);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.insert(awaited_replies.size(),
                                       apply_pool_op(s_tdata[2:0], s_tdata[12:3],
                                                     s_tdata[76:13], s_tdata[87:77],
                                                     s_tdata[98:88]));
            pending = awaited_replies.size();
        end
    end

endmodule

// File: dv/tb_node_pool_free_list_allocator.sv
// Testbench top for the node pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The block is driven with one operation per input item and returns one result
// item per operation. Stimulus opens with a short directed sequence that walks
// through every operation and every error status that a small pool can show,
// then runs a long random mix that works mostly on nodes which are really live.
// Both sides of the block idle at random between items, with stretches where
// neither side idles. The separate checker predicts every result and counts
// failures; this module only makes stimulus and decides the verdict.

module tb_node_pool_free_list_allocator;

    import npfla_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_IDLE      = 18;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 600000;
    // Opcodes above write links carry no operation and give a default reply.
    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int                  pending;
    int                  fail_count;
    int                  results_seen;
    int                  full_seen;
    int                  range_seen;
    int                  inactive_seen;
    int                  high_water;
    logic [CAPACITY-1:0] live_map;

    // When set, neither side inserts idle cycles, so items stream back to back.
    bit                  no_idle;
    int                  items_sent;
    int                  cycle_count = 0;
    int                  peak_live;

    node_pool_free_list_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    node_pool_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .pending       (pending),
        .fail_count    (fail_count),
        .results_seen  (results_seen),
        .full_seen     (full_seen),
        .range_seen    (range_seen),
        .inactive_seen (inactive_seen),
        .high_water    (high_water),
        .live_map      (live_map)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Guard against a hung handshake: the limit is several times the slowest
    // correct run, in which every item sees the longest gap on both sides.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d results still awaited.", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: for each result item the receiver draws a stall, holds
    // tready low for that many cycles, then keeps it high until a result leaves.
    initial begin : result_sink
        int stall;

        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    function automatic logic [LINK_W-1:0] rand_link();
        // A quarter of the links name no node; the rest cover all 11-bit values.
        if ($urandom_range(0, 3) == 0)
            return LINK_NONE;
        return LINK_W'($urandom_range(0, (1 << LINK_W) - 1));
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Picks a node below the high-water mark that is live (or not live, as
    // asked), starting from a random point so that all indices get their turn.
    function automatic bit find_node(input bit want_live, output logic [IDX_W-1:0] idx);
        int hw;
        int start;
        int k;
        int cand;

        hw  = high_water;
        idx = '0;
        if (hw == 0)
            return 1'b0;
        start = $urandom_range(0, hw - 1);
        for (k = 0; k < hw; k++) begin
            cand = (start + k) % hw;
            if (live_map[cand] == want_live) begin
                idx = IDX_W'(cand);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Presents one item after a random gap and returns at the falling edge
    // that follows its acceptance, with tvalid still high. A following item
    // with no gap therefore keeps tvalid high without a glitch.
    task automatic send_op(input logic [OPCODE_W-1:0]  op,
                           input logic [IDX_W-1:0]     idx,
                           input logic [PAYLOAD_W-1:0] payload,
                           input logic [LINK_W-1:0]    nxt,
                           input logic [LINK_W-1:0]    prv);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 99){1'b0}}, prv, nxt, payload, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if ($countones(live_map) > peak_live)
            peak_live = $countones(live_map);
    endtask

    // Acquire ignores every field except the payload, so the rest is random.
    task automatic send_acquire(input logic [PAYLOAD_W-1:0] payload);
        send_op(OP_ACQUIRE, IDX_W'($urandom), payload, rand_link(), rand_link());
    endtask

    // Holds the sender off until every awaited result has come back. The
    // extra falling edge keeps tvalid from being lowered and raised at once.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    // One random item. Most of them address a live node, so that stores,
    // links and the free stack are really exercised; the rest hit random
    // indices, nodes already released, and the spare opcodes.
    task automatic random_item();
        int                   pick;
        logic [IDX_W-1:0]     idx;
        logic [OPCODE_W-1:0]  op;
        bit                   found;

        pick = $urandom_range(0, 99);
        op   = OP_SPARE_FIRST;
        if (pick < 84)
            found = find_node(1'b1, idx);
        else if (pick < 94)
            found = find_node(1'b0, idx);
        else
            found = 1'b1;

        if (pick < 28 || !found) begin
            send_acquire(rand_payload());
        end else if (pick < 48) begin
            send_op(OP_RELEASE, idx, rand_payload(), rand_link(), rand_link());
        end else if (pick < 60) begin
            send_op(OP_READ_ORDER, idx, rand_payload(), rand_link(), rand_link());
        end else if (pick < 72) begin
            send_op(OP_READ_LINKS, idx, rand_payload(), rand_link(), rand_link());
        end else if (pick < 84) begin
            send_op(OP_WRITE_LINKS, idx, rand_payload(), rand_link(), rand_link());
        end else begin
            // Random index, a node that is not live, or a spare opcode.
            if (pick < 90 || pick >= 94)
                idx = IDX_W'($urandom);
            if (pick < 94)
                op = OPCODE_W'($urandom_range(OP_RELEASE, OP_WRITE_LINKS));
            else
                op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_op(op, idx, rand_payload(), rand_link(), rand_link());
        end
    endtask

    initial begin : stimulus
        int k;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_idle     = 1'b0;
        items_sent  = 0;
        peak_live   = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening. Nothing has been handed out yet, so any index is
        // out of range, even the lowest and the highest.
        send_op(OP_READ_ORDER, '0, '0, '0, '0);
        send_op(OP_RELEASE, '1, '1, '1, '1);
        // Three fresh nodes 0, 1 and 2 with extreme and patterned payloads.
        send_acquire('1);
        send_acquire('0);
        send_acquire(64'hA5A5_5A5A_F00F_0FF0);
        send_op(OP_READ_ORDER, IDX_W'(0), '0, '0, '0);
        send_op(OP_READ_LINKS, IDX_W'(1), '0, '0, '0);
        // Links are stored as given, without any check against the pool.
        send_op(OP_WRITE_LINKS, IDX_W'(1), '0, '0, '1);
        send_op(OP_READ_LINKS, IDX_W'(1), '0, '0, '0);
        send_op(OP_WRITE_LINKS, IDX_W'(2), '0, '1, '0);
        // A release followed by a second release of the same node is caught
        // as an inactive node, and so is every access to it.
        send_op(OP_RELEASE, IDX_W'(1), '0, '0, '0);
        send_op(OP_RELEASE, IDX_W'(1), '0, '0, '0);
        send_op(OP_READ_ORDER, IDX_W'(1), '0, '0, '0);
        send_op(OP_READ_LINKS, IDX_W'(1), '0, '0, '0);
        send_op(OP_WRITE_LINKS, IDX_W'(1), '0, LINK_NONE, LINK_NONE);
        // The free stack hands back indices most recently released first.
        send_acquire(64'h0123_4567_89AB_CDEF);
        send_op(OP_RELEASE, IDX_W'(0), '0, '0, '0);
        send_op(OP_RELEASE, IDX_W'(2), '0, '0, '0);
        send_acquire(64'h8000_0000_0000_0001);
        send_acquire(64'h7FFF_FFFF_FFFF_FFFE);
        // Free stack empty again: the next never-used index is taken.
        send_acquire(64'hDEAD_BEEF_CAFE_F00D);
        send_op(OP_SPARE_FIRST, '1, '1, '1, '1);
        send_op(OP_SPARE_MID, '0, '0, '0, '0);
        send_op(OP_SPARE_LAST, IDX_W'(3), '1, LINK_NONE, '0);
        send_op(OP_READ_ORDER, IDX_W'(5), '0, '0, '0);

        // The sender waits here for every awaited result before going on.
        drain();

        // Long random mix, switching now and then to a stretch with no idling.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (k == RANDOM_ITEMS / 2) begin
                no_idle = 1'b0;
                drain();
            end
            random_item();
        end
        no_idle = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d operations and checked %0d results, up to %0d nodes live at once.",
                 items_sent, results_seen, peak_live);
        $display("Error replies seen: %0d pool full, %0d out of range, %0d inactive node.",
                 full_seen, range_seen, inactive_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures, %0d results still awaited.", fail_count, pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/npfla_pkg.sv
src/npfla_store.sv
src/node_pool_free_list_allocator.sv
dv/node_pool_result_checker.sv
dv/tb_node_pool_free_list_allocator.sv
